[hdl/sle_pkg.sv]
// shared types and constants for the sequential list engine
// used by sle_datapath, sle_ctrl, sequential_list_engine and the sim files; no dependencies
package sle_pkg;

    localparam int MAX_SIZE  = 64;
    localparam int ADDR_W    = $clog2(MAX_SIZE);
    localparam int LEN_W     = 7;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 2'd0,
        KIND_LOCATE = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_DELETE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RSVD  = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic set_err;
        logic start;
        logic capture;
        logic step;
        logic put;
        logic shrink;
        logic publish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  err;
        logic  done;
        logic  match;
    } t_stat;

endpackage

[hdl/sle_datapath.sv]
// list storage, length, walk counters and result register of the list engine
// depends on sle_pkg
module sle_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sle_pkg::KIND_W-1:0]       i_kind,
    input  logic [sle_pkg::LEN_W-1:0]        i_position,
    input  logic [sle_pkg::DATA_W-1:0]       i_value,
    input  sle_pkg::t_cmd                    i_cmd,
    output sle_pkg::t_stat                   o_stat,
    output logic [sle_pkg::OUT_DATA_W-1:0]   o_result
);
    import sle_pkg::*;

    logic [DATA_W-1:0] r_mem [MAX_SIZE];
    logic [DATA_W-1:0] r_rdata;

    t_kind              r_kind;
    logic [LEN_W-1:0]   r_pos;
    logic [DATA_W-1:0]  r_value;
    logic [LEN_W-1:0]   r_len;
    logic [ADDR_W-1:0]  r_ptr;
    logic [LEN_W-1:0]   r_cnt;
    logic               r_pend;
    logic [ADDR_W-1:0]  r_paddr;
    t_status            r_status;
    logic [DATA_W-1:0]  r_elem;
    logic [LEN_W-1:0]   r_found;
    logic [OUT_DATA_W-1:0] r_out;

    logic [ADDR_W-1:0]  w_pos_idx;
    logic               w_pos_zero;
    logic               w_above_len;
    logic               w_above_len1;
    logic               w_full;
    logic               w_range;
    logic               w_err;
    logic               w_match;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [DATA_W-1:0]  w_wdata;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic               w_is_move;

    assign w_pos_idx    = ADDR_W'(r_pos - LEN_W'(1));
    assign w_pos_zero   = (r_pos == '0);
    assign w_above_len  = (r_pos > r_len);
    assign w_above_len1 = ({1'b0, r_pos} > ({1'b0, r_len} + (LEN_W+1)'(1)));
    assign w_full       = (r_len == LEN_W'(MAX_SIZE));
    assign w_is_move    = (r_kind == KIND_INSERT) || (r_kind == KIND_DELETE);
    assign w_match      = r_pend && (r_rdata == r_value) && (r_kind == KIND_LOCATE);

    always_comb begin
        w_range = 1'b0;
        w_err   = 1'b0;
        unique case (r_kind)
            KIND_GET, KIND_DELETE: begin
                w_range = w_pos_zero || w_above_len;
                w_err   = w_range;
            end
            KIND_INSERT: begin
                w_range = w_pos_zero || w_above_len1;
                w_err   = w_range || w_full;
            end
            default: begin
                w_range = 1'b0;
                w_err   = 1'b0;
            end
        endcase
    end

    assign o_stat.kind  = r_kind;
    assign o_stat.err   = w_err;
    assign o_stat.done  = (r_cnt == '0) && !r_pend;
    assign o_stat.match = w_match;

    // memory port selection
    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_ptr;
        w_we    = 1'b0;
        w_waddr = (r_kind == KIND_INSERT) ? r_paddr + ADDR_W'(1) : r_paddr - ADDR_W'(1);
        w_wdata = r_rdata;
        if (i_cmd.start && ((r_kind == KIND_GET) || (r_kind == KIND_DELETE))) begin
            w_re    = 1'b1;
            w_raddr = w_pos_idx;
        end
        if (i_cmd.step && (r_cnt != '0)) begin
            w_re    = 1'b1;
            w_raddr = r_ptr;
        end
        if (i_cmd.step && r_pend && w_is_move) begin
            w_we = 1'b1;
        end
        if (i_cmd.put) begin
            w_we    = 1'b1;
            w_waddr = w_pos_idx;
            w_wdata = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // request, result and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_kind   <= t_kind'(i_kind);
                r_pos    <= i_position;
                r_value  <= i_value;
                r_status <= STATUS_OK;
                r_elem   <= '0;
                r_found  <= '0;
            end
            if (i_cmd.set_err) begin
                r_status <= w_range ? STATUS_RANGE : STATUS_FULL;
            end
            if (i_cmd.start) begin
                r_pend <= 1'b0;
                if (r_kind == KIND_INSERT) begin
                    r_ptr <= ADDR_W'(r_len - LEN_W'(1));
                    r_cnt <= r_len - r_pos + LEN_W'(1);
                end else begin
                    r_ptr <= '0;
                    r_cnt <= (r_kind == KIND_LOCATE) ? r_len : '0;
                end
            end
            if (i_cmd.capture) begin
                r_elem <= r_rdata;
                r_ptr  <= ADDR_W'(r_pos);
                r_cnt  <= (r_kind == KIND_DELETE) ? r_len - r_pos : '0;
                r_pend <= 1'b0;
            end
            if (i_cmd.step) begin
                if (r_cnt != '0) begin
                    r_ptr   <= (r_kind == KIND_INSERT) ? r_ptr - ADDR_W'(1)
                                                       : r_ptr + ADDR_W'(1);
                    r_cnt   <= r_cnt - LEN_W'(1);
                    r_pend  <= 1'b1;
                    r_paddr <= r_ptr;
                end else begin
                    r_pend <= 1'b0;
                end
                if (w_match) begin
                    r_found <= LEN_W'(r_paddr) + LEN_W'(1);
                end
            end
            if (i_cmd.put) begin
                r_len <= r_len + LEN_W'(1);
            end
            if (i_cmd.shrink) begin
                r_len <= r_len - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out <= {7'd0, (r_len == '0), r_len, r_found, r_elem, r_status};
        end
    end

    assign o_result = r_out;

endmodule

[hdl/sle_ctrl.sv]
// request sequencer and handshake control of the list engine
// depends on sle_pkg
module sle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  sle_pkg::t_stat i_stat,
    output sle_pkg::t_cmd  o_cmd
);
    import sle_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_READ   = 6'b000100,
        ST_MOVE   = 6'b001000,
        ST_PUT    = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.err) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = ST_FINISH;
                end else begin
                    o_cmd.start = 1'b1;
                    if ((i_stat.kind == KIND_GET) || (i_stat.kind == KIND_DELETE)) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_MOVE;
                    end
                end
            end
            ST_READ: begin
                o_cmd.capture = 1'b1;
                n_state = (i_stat.kind == KIND_DELETE) ? ST_MOVE : ST_FINISH;
            end
            ST_MOVE: begin
                o_cmd.step = 1'b1;
                if (i_stat.match) begin
                    n_state = ST_FINISH;
                end else if (i_stat.done) begin
                    if (i_stat.kind == KIND_INSERT) begin
                        n_state = ST_PUT;
                    end else begin
                        o_cmd.shrink = (i_stat.kind == KIND_DELETE);
                        n_state      = ST_FINISH;
                    end
                end
            end
            ST_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hdl/sequential_list_engine.sv]
// top level of the sequential list engine: ordered list with get, locate, insert, delete
// depends on sle_pkg, sle_datapath and sle_ctrl
// one request at a time; the next is taken in the cycle after publish
// reset (synchronous, active low) empties the list and drops any pending result
module sequential_list_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata fields from bit 0: position[6:0], value[38:7], zero pad [39]
    input  logic [sle_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // tuser fields from bit 0: kind[1:0]
    input  logic [sle_pkg::KIND_W-1:0]          i_s_tuser,
    // result channel
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata fields from bit 0: status[1:0], element[33:2], found_position[40:34],
    // count[47:41], is_empty[48], zero pad [55:49]
    output logic [sle_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import sle_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // datapath holds storage, length and the result register
    sle_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_kind     (i_s_tuser),
        .i_position (i_s_tdata[LEN_W-1:0]),
        .i_value    (i_s_tdata[LEN_W +: DATA_W]),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_result   (o_m_tdata)
    );

    // controller sequences each request and owns both handshakes
    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // only one request in work: no item is taken right after another
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("item accepted while a request was in work");

    // list length never exceeds capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[47:41] <= LEN_W'(MAX_SIZE)))
        else $error("count above capacity");

    // empty flag follows the count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[48] == (o_m_tdata[47:41] == '0)))
        else $error("is_empty disagrees with count");

    // errors carry no element and no found position
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] != STATUS_OK)) |->
            ((o_m_tdata[33:2] == '0) && (o_m_tdata[40:34] == '0)))
        else $error("error result with payload");

endmodule

[sim/list_check_pkg.sv]
// scoreboard for the sequential list engine: a shadow list that predicts each result
// and a queue of predicted results that every returned item is checked against
// depends on sle_pkg for the request kinds, the status codes and the bus widths
`timescale 1ns / 1ps

package list_check_pkg;

    import sle_pkg::*;

    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] element;
        logic [LEN_W-1:0]  found_pos;
        logic [LEN_W-1:0]  count;
        logic              is_empty;
    } t_list_result;

    class t_list_scoreboard;
        logic [DATA_W-1:0] entries [MAX_SIZE];
        int                fill_len;
        t_list_result      pending_q [$];
        int                errors;
        int                checked;
        int                kind_cnt [4];
        int                range_cnt;
        int                full_cnt;
        int                hit_cnt;
        int                peak_len;

        function new();
            fill_len  = 0;
            errors    = 0;
            checked   = 0;
            range_cnt = 0;
            full_cnt  = 0;
            hit_cnt   = 0;
            peak_len  = 0;
            foreach (kind_cnt[k]) kind_cnt[k] = 0;
        endfunction

        // update the shadow list for one accepted request and queue its result
        function void note_request(t_kind kind, logic [LEN_W-1:0] pos,
                                   logic [DATA_W-1:0] value);
            t_list_result res;
            int           p;
            res = '0;
            res.status = STATUS_OK;
            p = int'(pos);
            kind_cnt[int'(kind)]++;
            case (kind)
                KIND_GET: begin
                    if (p < 1 || p > fill_len) res.status = STATUS_RANGE;
                    else res.element = entries[p-1];
                end
                KIND_LOCATE: begin
                    for (int i = 0; i < fill_len && res.found_pos == '0; i++)
                        if (entries[i] == value) res.found_pos = LEN_W'(i + 1);
                    if (res.found_pos != '0) hit_cnt++;
                end
                KIND_INSERT: begin
                    // range is checked before fullness
                    if (p < 1 || p > fill_len + 1) begin
                        res.status = STATUS_RANGE;
                    end else if (fill_len >= MAX_SIZE) begin
                        res.status = STATUS_FULL;
                    end else begin
                        for (int i = fill_len; i > p - 1; i--) entries[i] = entries[i-1];
                        entries[p-1] = value;
                        fill_len++;
                    end
                end
                default: begin
                    if (p < 1 || p > fill_len) begin
                        res.status = STATUS_RANGE;
                    end else begin
                        res.element = entries[p-1];
                        for (int i = p; i < fill_len; i++) entries[i-1] = entries[i];
                        fill_len--;
                    end
                end
            endcase
            if (res.status == STATUS_RANGE) range_cnt++;
            if (res.status == STATUS_FULL) full_cnt++;
            if (fill_len > peak_len) peak_len = fill_len;
            res.count    = LEN_W'(fill_len);
            res.is_empty = (fill_len == 0);
            pending_q.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < MAX_PRINTS)
                $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                         checked, what, got, want);
            errors++;
        endtask

        // compare one returned item with the oldest predicted result
        task check_result(logic [OUT_DATA_W-1:0] data);
            t_list_result want;
            checked++;
            if (pending_q.size() == 0) begin
                report("result with nothing pending, tdata", 64'(data), 64'd0);
            end else begin
                want = pending_q.pop_front();
                if (data[1:0] != want.status)
                    report("status", 64'(data[1:0]), 64'(want.status));
                if (data[33:2] != want.element)
                    report("element", 64'(data[33:2]), 64'(want.element));
                if (data[40:34] != want.found_pos)
                    report("found_position", 64'(data[40:34]), 64'(want.found_pos));
                if (data[47:41] != want.count)
                    report("count", 64'(data[47:41]), 64'(want.count));
                if (data[48] != want.is_empty)
                    report("is_empty", 64'(data[48]), 64'(want.is_empty));
                if (data[55:49] != '0)
                    report("pad bits", 64'(data[55:49]), 64'd0);
            end
        endtask

        task check_leftovers();
            while (pending_q.size() != 0) begin
                report("result never returned, count", 64'(pending_q[0].count), 64'd0);
                void'(pending_q.pop_front());
            end
        endtask
    endclass

endpackage

[sim/sequential_list_engine_tb.sv]
// testbench for sequential_list_engine: directed corner requests, then random
// grow/shrink sweeps of the list under changing backpressure; depends on sle_pkg and
// list_check_pkg, whose scoreboard predicts and checks every result item
`timescale 1ns / 1ps

module sequential_list_engine_tb;

    import sle_pkg::*;
    import list_check_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1350;
    localparam int SETTLE_CYCLES = MAX_SIZE + 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // tdata fields from bit 0: position[6:0], value[38:7], zero pad [39]
    logic [IN_DATA_W-1:0]  i_s_tdata;
    // tuser fields from bit 0: kind[1:0]
    logic [KIND_W-1:0]     i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // tdata fields from bit 0: status[1:0], element[33:2], found_position[40:34],
    // count[47:41], is_empty[48], zero pad [55:49]
    logic [OUT_DATA_W-1:0] o_m_tdata;

    t_list_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             cycle_cnt = 0;
    bit             growing;

    sequential_list_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, sb.pending_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check at each accepting edge, then pick the next ready level
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // present one request, with a random idle gap ahead of it, and wait for acceptance
    task automatic send_item(t_kind kind, logic [LEN_W-1:0] pos, logic [DATA_W-1:0] value);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            // junk on the bus while valid is low
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= IN_DATA_W'({$urandom, $urandom});
            i_s_tuser  <= KIND_W'($urandom_range(0, 3));
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {1'b0, value, pos};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(kind, pos, value);
    endtask

    // drop valid and hold off until every pending result is back
    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_q.size() != 0);
    endtask

    task automatic run_directed();
        // empty list: every positional request is out of range
        send_item(KIND_GET,    7'd1,   32'd0);
        send_item(KIND_DELETE, 7'd1,   32'd0);
        send_item(KIND_LOCATE, 7'd0,   32'd0);
        send_item(KIND_INSERT, 7'd0,   32'd5);
        send_item(KIND_INSERT, 7'd2,   32'd5);
        // build min, 0, max, -1 through front, middle and tail inserts
        send_item(KIND_INSERT, 7'd1,   32'h7FFF_FFFF);
        send_item(KIND_INSERT, 7'd1,   32'h8000_0000);
        send_item(KIND_INSERT, 7'd3,   32'hFFFF_FFFF);
        send_item(KIND_INSERT, 7'd2,   32'd0);
        send_item(KIND_INSERT, 7'd6,   32'd5);
        // reads at both ends and past the end
        send_item(KIND_GET,    7'd1,   32'd0);
        send_item(KIND_GET,    7'd4,   32'd0);
        send_item(KIND_GET,    7'd5,   32'd0);
        send_item(KIND_GET,    7'd0,   32'd0);
        send_item(KIND_GET,    7'd127, 32'hFFFF_FFFF);
        // hits at the tail and in the middle, then a miss
        send_item(KIND_LOCATE, 7'd0,   32'hFFFF_FFFF);
        send_item(KIND_LOCATE, 7'd127, 32'h7FFF_FFFF);
        send_item(KIND_LOCATE, 7'd0,   32'd12345);
        // duplicate value: locate must return the first match
        send_item(KIND_INSERT, 7'd2,   32'hFFFF_FFFF);
        send_item(KIND_LOCATE, 7'd0,   32'hFFFF_FFFF);
        // remove tail and head, then bad positions
        send_item(KIND_DELETE, 7'd5,   32'd0);
        send_item(KIND_DELETE, 7'd1,   32'd0);
        send_item(KIND_DELETE, 7'd0,   32'd0);
        send_item(KIND_DELETE, 7'd127, 32'd0);
        send_item(KIND_INSERT, 7'd127, 32'd1);
    endtask

    // random request biased to sweep the list between empty and full
    task automatic send_random_item();
        t_kind             kind;
        int                len;
        int                top;
        int                roll;
        logic [LEN_W-1:0]  pos;
        logic [DATA_W-1:0] value;
        len = sb.fill_len;
        // turn around a few requests after reaching either end
        if (growing && len == MAX_SIZE && $urandom_range(0, 3) == 0) growing = 1'b0;
        if (!growing && len == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
        if ($urandom_range(0, 199) == 0) growing = !growing;

        roll = $urandom_range(0, 99);
        if (roll < 55)      kind = growing ? KIND_INSERT : KIND_DELETE;
        else if (roll < 65) kind = growing ? KIND_DELETE : KIND_INSERT;
        else if (roll < 85) kind = KIND_GET;
        else                kind = KIND_LOCATE;

        // mostly legal positions, many at the ends, some anywhere in the field
        top = (kind == KIND_INSERT) ? len + 1 : len;
        roll = $urandom_range(0, 99);
        if (roll < 12 || top == 0) pos = LEN_W'($urandom_range(0, 127));
        else if (roll < 30)        pos = 7'd1;
        else if (roll < 48)        pos = LEN_W'(top);
        else                       pos = LEN_W'($urandom_range(1, top));

        // small values give duplicates, extremes hit the sign edges
        roll = $urandom_range(0, 99);
        if (kind == KIND_LOCATE && len > 0 && roll < 60) begin
            value = sb.entries[$urandom_range(0, len - 1)];
        end else if (roll < 35) begin
            value = DATA_W'($urandom_range(0, 7)) - 32'd4;
        end else if (roll < 45) begin
            case ($urandom_range(0, 3))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = 32'h0000_0000;
                default: value = 32'hFFFF_FFFF;
            endcase
        end else begin
            value = $urandom;
        end
        send_item(kind, pos, value);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        send_idle_pct  = 30;
        recv_stall_pct = 63;
        growing        = 1'b1;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        hold_until_drained();

        // three idling regimes: slow sender/slow receiver swapped, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 30 : (phase == 1) ? 63 : 0;
            recv_stall_pct = (phase == 0) ? 63 : (phase == 1) ? 30 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                send_random_item();
                if ($urandom_range(0, 99) == 0) hold_until_drained();
            end
            hold_until_drained();
        end

        // a late or extra result would show up during this settle time
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_leftovers();

        $display("requests: %0d get, %0d locate, %0d insert, %0d delete; %0d results checked",
                 sb.kind_cnt[KIND_GET], sb.kind_cnt[KIND_LOCATE],
                 sb.kind_cnt[KIND_INSERT], sb.kind_cnt[KIND_DELETE], sb.checked);
        $display("range errors %0d, full rejections %0d, locate hits %0d, peak length %0d",
                 sb.range_cnt, sb.full_cnt, sb.hit_cnt, sb.peak_len);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
